### hdl/gmfn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the grid mesh face normal unit.
// Used by the front, back, normal datapath and top level; no dependencies.

package gmfn_pkg;

    // configuration register width and indexes
    localparam int CFG_W = 9;
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;
    localparam logic [CFG_W-1:0] EXTENT_RESET = 9'd16;

    // fraction bits of the unit normal
    localparam int FRAC_W = 14;

    // result payload width: vertex, normal, index
    localparam int OUT_W = 112;

    // one vertex position, x in the low bits
    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } vtx_t;

    // one face normal, x in the low bits
    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } norm_t;

    // the four vertices of one completed cell
    typedef struct packed {
        vtx_t cur;
        vtx_t above;
        vtx_t disp;
        vtx_t prev;
    } job_t;

endpackage

`default_nettype wire

### hdl/gmfn_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module gmfn_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  wire logic                             aclk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/gmfn_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-entry job queue between the front and back of the face normal unit.
// No dependencies.

module gmfn_fifo #(
    parameter int WIDTH = 192
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] head,
    output logic                  empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    // store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/gmfn_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front of the face normal unit: accepts grid vertices, tracks grid position,
// keeps the previous column in a RAM and queues completed cells. Uses gmfn_pkg, gmfn_ram.

module gmfn_front import gmfn_pkg::*; #(
    parameter int MAX_INNER = 256,
    parameter int MAX_OUTER = 256
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [CFG_W-1:0] grid_rows,
    input  wire logic [CFG_W-1:0] grid_columns,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire vtx_t             s_vtx,
    output logic                  push,
    output job_t                  push_job,
    input  wire logic             full
);

    localparam int IW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int OW = (MAX_OUTER > 1) ? $clog2(MAX_OUTER) : 1;
    localparam int CW = (IW + 1 > CFG_W) ? IW + 1 : CFG_W;
    localparam int RW = (OW + 1 > CFG_W) ? OW + 1 : CFG_W;

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_READ = 2'b10
    } front_state_t;

    front_state_t   state_reg;
    logic [IW-1:0]  inner_reg;
    logic [OW-1:0]  outer_reg;
    vtx_t           cur_reg;
    vtx_t           disp_reg;
    vtx_t           prev_reg;
    vtx_t           above;
    logic           s_fire;
    logic           completes;
    logic           advance;
    logic [CW-1:0]  cols_ext;
    logic [CW-1:0]  cols_eff;
    logic [CW-1:0]  inner_inc;
    logic [RW-1:0]  rows_ext;
    logic [RW-1:0]  rows_eff;
    logic [RW-1:0]  outer_inc;

    assign s_tready = (state_reg == F_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // previous column store, read at accept, written back when the step retires
    gmfn_ram #(
        .WIDTH ($bits(vtx_t)),
        .DEPTH (MAX_INNER)
    ) u_column_ram (
        .aclk  (aclk),
        .we    (advance),
        .waddr (inner_reg),
        .wdata (cur_reg),
        .re    (s_fire),
        .raddr (inner_reg),
        .rdata (above)
    );

    // clamp extents to the supported range
    always_comb begin
        cols_ext = CW'(grid_columns);
        if (cols_ext < CW'(2)) begin
            cols_eff = CW'(2);
        end else if (cols_ext > CW'(MAX_INNER)) begin
            cols_eff = CW'(MAX_INNER);
        end else begin
            cols_eff = cols_ext;
        end
        rows_ext = RW'(grid_rows);
        if (rows_ext < RW'(2)) begin
            rows_eff = RW'(2);
        end else if (rows_ext > RW'(MAX_OUTER)) begin
            rows_eff = RW'(MAX_OUTER);
        end else begin
            rows_eff = rows_ext;
        end
        inner_inc = CW'(inner_reg) + CW'(1);
        outer_inc = RW'(outer_reg) + RW'(1);
    end

    // classify: a cell completes away from the first row and column
    assign completes = (outer_reg != '0) && (inner_reg != '0);
    assign advance   = (state_reg == F_READ) && (!completes || !full);
    assign push      = (state_reg == F_READ) && completes && !full;
    assign push_job  = '{cur: cur_reg, above: above, disp: disp_reg, prev: prev_reg};

    // capture the vertex, then retire the step and move the grid position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            inner_reg <= '0;
            outer_reg <= '0;
            disp_reg  <= '0;
            prev_reg  <= '0;
        end else begin
            if (s_fire) begin
                state_reg <= F_READ;
            end
            if (advance) begin
                state_reg <= F_IDLE;
                disp_reg  <= above;
                prev_reg  <= cur_reg;
                if (inner_inc >= cols_eff) begin
                    inner_reg <= '0;
                    if (outer_inc >= rows_eff) begin
                        outer_reg <= '0;
                    end else begin
                        outer_reg <= outer_inc[OW-1:0];
                    end
                end else begin
                    inner_reg <= inner_inc[IW-1:0];
                end
            end
        end
    end

    // hold the accepted vertex
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cur_reg <= s_vtx;
        end
    end

endmodule

`default_nettype wire

### hdl/gmfn_normal.sv
`timescale 1ns / 1ps
`default_nettype none
// Iterative unit face normal: cross product on one shared multiplier,
// prescale, bit-pair square root and restoring division. Uses gmfn_pkg.

module gmfn_normal import gmfn_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic start,
    input  wire vtx_t p1,
    input  wire vtx_t p2,
    input  wire vtx_t p3,
    output logic      done,
    output norm_t     normal
);

    typedef enum logic [8:0] {
        N_IDLE  = 9'b000000001,
        N_MUL   = 9'b000000010,
        N_ABS   = 9'b000000100,
        N_SCALE = 9'b000001000,
        N_SQ    = 9'b000010000,
        N_SQRT  = 9'b000100000,
        N_DIVLD = 9'b001000000,
        N_DIV   = 9'b010000000,
        N_DONE  = 9'b100000000
    } norm_state_t;

    norm_state_t        state_reg;
    logic signed [16:0] a_reg [3];
    logic signed [16:0] b_reg [3];
    logic signed [33:0] prod_reg;
    logic signed [34:0] c_reg [3];
    logic [34:0]        m_reg [3];
    logic [2:0]         neg_reg;
    logic [2:0]         cnt_reg;
    logic [59:0]        sq_reg;
    logic [63:0]        s_reg;
    logic [63:0]        res_reg;
    logic [63:0]        bit_reg;
    logic [31:0]        len_reg;
    logic [45:0]        rem_reg;
    logic [14:0]        q_reg;
    logic [3:0]         dcnt_reg;
    logic signed [15:0] n_reg [3];

    logic signed [16:0] op_a;
    logic signed [16:0] op_b;
    logic [34:0]        m_sel;
    logic [1:0]         acc_idx;
    logic               big;
    logic [63:0]        trial;
    logic [45:0]        divisor;
    logic               ge;
    logic [14:0]        q_nx;
    logic [15:0]        q_ext;

    assign done   = (state_reg == N_DONE);
    assign normal = '{z: n_reg[2], y: n_reg[1], x: n_reg[0]};

    // operand pairs of the cross product: c0 = ay*bz - az*by, c1 = az*bx - ax*bz,
    // c2 = ax*by - ay*bx
    always_comb begin
        case (cnt_reg)
            3'd0: begin op_a = a_reg[1]; op_b = b_reg[2]; end
            3'd1: begin op_a = a_reg[2]; op_b = b_reg[1]; end
            3'd2: begin op_a = a_reg[2]; op_b = b_reg[0]; end
            3'd3: begin op_a = a_reg[0]; op_b = b_reg[2]; end
            3'd4: begin op_a = a_reg[0]; op_b = b_reg[1]; end
            3'd5: begin op_a = a_reg[1]; op_b = b_reg[0]; end
            default: begin op_a = '0; op_b = '0; end
        endcase
        acc_idx = 2'((cnt_reg - 3'd1) >> 1);
        case (cnt_reg)
            3'd0: m_sel = m_reg[0];
            3'd1: m_sel = m_reg[1];
            3'd2: m_sel = m_reg[2];
            default: m_sel = '0;
        endcase
        big     = (|m_reg[0][34:30]) || (|m_reg[1][34:30]) || (|m_reg[2][34:30]);
        trial   = res_reg + bit_reg;
        divisor = 46'(len_reg) << dcnt_reg;
        ge      = (rem_reg >= divisor);
        q_nx    = ge ? (q_reg | (15'd1 << dcnt_reg)) : q_reg;
        q_ext   = {1'b0, q_nx};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
        end else begin
            case (state_reg)
                // latch edge vectors
                N_IDLE: begin
                    if (start) begin
                        a_reg[0]  <= 17'(p2.x) - 17'(p1.x);
                        a_reg[1]  <= 17'(p2.y) - 17'(p1.y);
                        a_reg[2]  <= 17'(p2.z) - 17'(p1.z);
                        b_reg[0]  <= 17'(p3.x) - 17'(p1.x);
                        b_reg[1]  <= 17'(p3.y) - 17'(p1.y);
                        b_reg[2]  <= 17'(p3.z) - 17'(p1.z);
                        cnt_reg   <= '0;
                        state_reg <= N_MUL;
                    end
                end
                // one product a cycle, accumulate the previous one
                N_MUL: begin
                    prod_reg <= op_a * op_b;
                    if (cnt_reg != 3'd0) begin
                        if (cnt_reg[0]) begin
                            c_reg[acc_idx] <= 35'(prod_reg);
                        end else begin
                            c_reg[acc_idx] <= c_reg[acc_idx] - 35'(prod_reg);
                        end
                    end
                    if (cnt_reg == 3'd6) begin
                        state_reg <= N_ABS;
                    end
                    cnt_reg <= cnt_reg + 3'd1;
                end
                // magnitudes and signs; a zero cross product gives a zero normal
                N_ABS: begin
                    for (int j = 0; j < 3; j++) begin
                        m_reg[j]   <= c_reg[j][34] ? 35'(-c_reg[j]) : 35'(c_reg[j]);
                        neg_reg[j] <= c_reg[j][34];
                    end
                    if (c_reg[0] == '0 && c_reg[1] == '0 && c_reg[2] == '0) begin
                        for (int j = 0; j < 3; j++) begin
                            n_reg[j] <= '0;
                        end
                        state_reg <= N_DONE;
                    end else begin
                        state_reg <= N_SCALE;
                    end
                end
                // shift until every magnitude is below 2^30
                N_SCALE: begin
                    if (big) begin
                        for (int j = 0; j < 3; j++) begin
                            m_reg[j] <= m_reg[j] >> 1;
                        end
                    end else begin
                        cnt_reg   <= '0;
                        s_reg     <= '0;
                        state_reg <= N_SQ;
                    end
                end
                // sum of squares, one square a cycle
                N_SQ: begin
                    sq_reg <= m_sel[29:0] * m_sel[29:0];
                    if (cnt_reg != 3'd0) begin
                        s_reg <= s_reg + 64'(sq_reg);
                    end
                    if (cnt_reg == 3'd3) begin
                        res_reg   <= '0;
                        bit_reg   <= 64'd1 << 62;
                        state_reg <= N_SQRT;
                    end
                    cnt_reg <= cnt_reg + 3'd1;
                end
                // integer square root, one bit pair a cycle
                N_SQRT: begin
                    if (bit_reg == '0) begin
                        len_reg   <= res_reg[31:0];
                        cnt_reg   <= '0;
                        state_reg <= N_DIVLD;
                    end else begin
                        if (s_reg >= trial) begin
                            s_reg   <= s_reg - trial;
                            res_reg <= (res_reg >> 1) + bit_reg;
                        end else begin
                            res_reg <= res_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                // rounded dividend for one component
                N_DIVLD: begin
                    rem_reg   <= {2'b00, m_sel[29:0], {FRAC_W{1'b0}}} + 46'(len_reg >> 1);
                    q_reg     <= '0;
                    dcnt_reg  <= 4'd14;
                    state_reg <= N_DIV;
                end
                // restoring division, one quotient bit a cycle
                N_DIV: begin
                    if (ge) begin
                        rem_reg <= rem_reg - divisor;
                    end
                    q_reg <= q_nx;
                    if (dcnt_reg == 4'd0) begin
                        n_reg[cnt_reg[1:0]] <= neg_reg[cnt_reg[1:0]] ? -q_ext : q_ext;
                        if (cnt_reg == 3'd2) begin
                            state_reg <= N_DONE;
                        end else begin
                            cnt_reg   <= cnt_reg + 3'd1;
                            state_reg <= N_DIVLD;
                        end
                    end else begin
                        dcnt_reg <= dcnt_reg - 4'd1;
                    end
                end
                N_DONE: begin
                    state_reg <= N_IDLE;
                end
                default: begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/gmfn_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back of the face normal unit: takes queued cells, computes both triangle
// normals and emits six vertices through an output register. Uses gmfn_pkg, gmfn_normal.

module gmfn_back import gmfn_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire job_t             head,
    input  wire logic             empty,
    output logic                  pop,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [OUT_W-1:0] m_tdata,
    output logic                  m_tlast
);

    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_START1 = 6'b000010,
        B_WAIT1 = 6'b000100,
        B_START2 = 6'b001000,
        B_WAIT2 = 6'b010000,
        B_EMIT  = 6'b100000
    } back_state_t;

    back_state_t      state_reg;
    job_t             job_reg;
    norm_t            n1_reg;
    norm_t            n2_reg;
    logic [2:0]       k_reg;
    logic [15:0]      idx_reg;
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic             m_tlast_reg;

    logic             start;
    logic             second;
    vtx_t             p1;
    vtx_t             p2;
    vtx_t             p3;
    logic             n_done;
    norm_t            n_val;
    logic             load;
    vtx_t             v_sel;
    norm_t            n_sel;

    assign pop    = (state_reg == B_IDLE) && !empty;
    assign start  = (state_reg == B_START1) || (state_reg == B_START2);
    assign second = (state_reg == B_START2);
    assign load   = (state_reg == B_EMIT) && (!m_tvalid_reg || m_tready);

    // triangle one: prev, displaced, above; triangle two: above, cur, prev
    assign p1 = second ? job_reg.above : job_reg.prev;
    assign p2 = second ? job_reg.cur   : job_reg.disp;
    assign p3 = second ? job_reg.prev  : job_reg.above;

    gmfn_normal u_normal (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .p1      (p1),
        .p2      (p2),
        .p3      (p3),
        .done    (n_done),
        .normal  (n_val)
    );

    // pick the vertex and normal of the current output slot
    always_comb begin
        case (k_reg)
            3'd0: begin v_sel = job_reg.prev;  n_sel = n1_reg; end
            3'd1: begin v_sel = job_reg.disp;  n_sel = n1_reg; end
            3'd2: begin v_sel = job_reg.above; n_sel = n1_reg; end
            3'd3: begin v_sel = job_reg.above; n_sel = n2_reg; end
            3'd4: begin v_sel = job_reg.cur;   n_sel = n2_reg; end
            default: begin v_sel = job_reg.prev; n_sel = n2_reg; end
        endcase
    end

    // sequence the two normals and the six transfers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            k_reg        <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                B_IDLE: begin
                    if (!empty) begin
                        state_reg <= B_START1;
                    end
                end
                B_START1: state_reg <= B_WAIT1;
                B_WAIT1: begin
                    if (n_done) begin
                        state_reg <= B_START2;
                    end
                end
                B_START2: state_reg <= B_WAIT2;
                B_WAIT2: begin
                    if (n_done) begin
                        k_reg     <= '0;
                        state_reg <= B_EMIT;
                    end
                end
                B_EMIT: begin
                    if (load) begin
                        k_reg   <= k_reg + 3'd1;
                        idx_reg <= idx_reg + 16'd1;
                        if (k_reg == 3'd5) begin
                            state_reg <= B_IDLE;
                        end
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // hold job, normals and output payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= head;
        end
        if (n_done && state_reg == B_WAIT1) begin
            n1_reg <= n_val;
        end
        if (n_done && state_reg == B_WAIT2) begin
            n2_reg <= n_val;
        end
        if (load) begin
            m_tdata_reg <= {idx_reg, n_sel, v_sel};
            m_tlast_reg <= (k_reg == 3'd5);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

### hdl/grid_mesh_face_normals_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Grid mesh face normal unit.
// Grid vertices enter on the s_ stream, column by column, inner index fast.
// Each vertex that completes a cell (not on the first column or first inner
// position) produces six transfers on the m_ stream: the cell's two
// triangles, each vertex carrying its triangle's unit normal in Q1.14, a
// running 16-bit index and tlast on the sixth. Other vertices give nothing.
// The cfg channel writes grid_rows (index 0) and grid_columns (index 1);
// write only while the block is idle. cfg_ready is always high.
// The front takes a vertex, then retires it before taking the next, into a
// two-entry cell queue. The back computes each normal on one iterative unit:
// cross product, prescale, sum of squares, square root and division, in that
// order, and takes a new cell from the queue only when done with the last;
// the rate of completing vertices is set by that shared unit.
// Reset (aresetn low, synchronous) clears the grid position, the running
// index, the queue and the output register; the column RAM is not cleared.
// When the receiver stalls, the output register holds its transfer, the
// back waits, the queue fills and then s_tready drops.

module grid_mesh_face_normals_unit import gmfn_pkg::*; #(
    parameter int MAX_INNER = 256,
    parameter int MAX_OUTER = 256
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [47:0]      s_tdata,   // pos_x, pos_y, pos_z
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [OUT_W-1:0] m_tdata,   // out_x, out_y, out_z, normal_x,
                                             // normal_y, normal_z, vertex_index
    output logic                  m_tlast    // last_of_run
);

    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    logic             push;
    job_t             push_job;
    logic             full;
    logic             pop;
    job_t             head;
    logic             empty;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= EXTENT_RESET;
            cols_reg <= EXTENT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ROWS: rows_reg <= cfg_data;
                CFG_COLS: cols_reg <= cfg_data;
                default:  rows_reg <= rows_reg;
            endcase
        end
    end

    gmfn_front #(
        .MAX_INNER (MAX_INNER),
        .MAX_OUTER (MAX_OUTER)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .grid_rows    (rows_reg),
        .grid_columns (cols_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_vtx        (vtx_t'(s_tdata)),
        .push         (push),
        .push_job     (push_job),
        .full         (full)
    );

    gmfn_fifo #(
        .WIDTH ($bits(job_t))
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_job),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    gmfn_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### hdl/gmfn_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for the grid mesh face normal unit, bound to the top level.
// Uses gmfn_pkg.

module gmfn_checker import gmfn_pkg::*; (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata,
    input wire logic             m_tlast
);

    logic        out_fire;
    logic [2:0]  slot_reg;
    logic [15:0] last_idx_reg;
    logic        seen_reg;

    assign out_fire = m_tvalid && m_tready;

    // track the slot within a run and the last index seen
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            seen_reg <= 1'b0;
        end else if (out_fire) begin
            slot_reg     <= (slot_reg == 3'd5) ? 3'd0 : slot_reg + 3'd1;
            seen_reg     <= 1'b1;
            last_idx_reg <= m_tdata[111:96];
        end
    end

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("m_tdata changed while stalled");

    a_last_sixth: assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire |-> (m_tlast == (slot_reg == 3'd5)))
        else $error("tlast not on the sixth transfer of a run");

    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire && seen_reg |-> m_tdata[111:96] == last_idx_reg + 16'd1)
        else $error("vertex index did not advance by one");

endmodule

bind grid_mesh_face_normals_unit gmfn_checker u_gmfn_checker (.*);

`default_nettype wire

### bench/grid_mesh_face_normals_checker.sv
`timescale 1ns / 1ps
// Checker for the grid mesh face normal unit: watches the cfg, s_ and m_ channels,
// predicts the triangle vertices, normals and running index of every completed
// cell, and compares each m_ transfer in order. Depends on gmfn_pkg.

module grid_mesh_face_normals_checker import gmfn_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    input  wire logic             cfg_ready,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             s_tvalid,
    input  wire logic             s_tready,
    input  wire logic [47:0]      s_tdata,
    input  wire logic             m_tvalid,
    input  wire logic             m_tready,
    input  wire logic [OUT_W-1:0] m_tdata,
    input  wire logic             m_tlast,
    output int                    error_count,
    output int                    pending
);

    localparam int GRID_MAX = 256;

    typedef struct {
        vtx_t        v;
        norm_t       n;
        logic [15:0] idx;
        logic        last;
    } tri_vertex_t;

    tri_vertex_t expected_vertices[$];

    // grid state of the prediction
    vtx_t        column_line[GRID_MAX];
    vtx_t        pushed_out;
    vtx_t        prior_vertex;
    int          outer_pos;
    int          inner_pos;
    logic [15:0] next_index;
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;

    string field_name[8] = '{"out_x", "out_y", "out_z", "normal_x", "normal_y",
                             "normal_z", "vertex_index", "last_of_run"};

    assign pending = expected_vertices.size();

    function automatic int clamp_extent(logic [CFG_W-1:0] v);
        if (v < 2) return 2;
        if (v > GRID_MAX) return GRID_MAX;
        return int'(v);
    endfunction

    // unit normal of (p2-p1) x (p3-p1) in Q1.14, zero when degenerate
    function automatic norm_t unit_normal(vtx_t p1, vtx_t p2, vtx_t p3);
        longint ax, ay, az, bx, by, bz;
        longint c[3];
        longint unsigned m[3];
        longint unsigned mx, rem, root, bitv, q;
        norm_t n;
        ax = longint'(p2.x) - longint'(p1.x);
        ay = longint'(p2.y) - longint'(p1.y);
        az = longint'(p2.z) - longint'(p1.z);
        bx = longint'(p3.x) - longint'(p1.x);
        by = longint'(p3.y) - longint'(p1.y);
        bz = longint'(p3.z) - longint'(p1.z);
        c[0] = ay * bz - az * by;
        c[1] = az * bx - ax * bz;
        c[2] = ax * by - ay * bx;
        for (int i = 0; i < 3; i++) m[i] = (c[i] < 0) ? longint'(-c[i]) : c[i];
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        n = '0;
        if (mx == 0) return n;
        // prescale so that every magnitude is below 2^30
        while (mx >= (64'd1 << 30)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        // integer square root of the sum of squares
        rem = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * 16384 + (root >> 1)) / root;
            if (i == 0) n.x = (c[i] < 0) ? 16'(-longint'(q)) : 16'(q);
            if (i == 1) n.y = (c[i] < 0) ? 16'(-longint'(q)) : 16'(q);
            if (i == 2) n.z = (c[i] < 0) ? 16'(-longint'(q)) : 16'(q);
        end
        return n;
    endfunction

    function automatic void push_vertex(vtx_t v, norm_t n, logic last);
        tri_vertex_t e;
        e.v = v;
        e.n = n;
        e.idx = next_index;
        e.last = last;
        expected_vertices.insert(expected_vertices.size(), e);
        next_index = next_index + 16'd1;
    endfunction

    // advance the grid by one vertex and queue the six vertices of any cell it completes
    function automatic void take_vertex(vtx_t cur);
        vtx_t  above;
        norm_t n1, n2;
        above = column_line[inner_pos];
        if (outer_pos > 0 && inner_pos > 0) begin
            n1 = unit_normal(prior_vertex, pushed_out, above);
            n2 = unit_normal(above, cur, prior_vertex);
            push_vertex(prior_vertex, n1, 1'b0);
            push_vertex(pushed_out, n1, 1'b0);
            push_vertex(above, n1, 1'b0);
            push_vertex(above, n2, 1'b0);
            push_vertex(cur, n2, 1'b0);
            push_vertex(prior_vertex, n2, 1'b1);
        end
        pushed_out = above;
        column_line[inner_pos] = cur;
        prior_vertex = cur;
        if (inner_pos + 1 >= clamp_extent(cols_reg)) begin
            inner_pos = 0;
            outer_pos = (outer_pos + 1 >= clamp_extent(rows_reg)) ? 0 : outer_pos + 1;
        end else begin
            inner_pos = inner_pos + 1;
        end
    endfunction

    initial error_count = 0;

    always @(posedge aclk) begin
        tri_vertex_t e;
        logic [15:0] want[8];
        logic [15:0] got[8];
        if (!aresetn) begin
            expected_vertices.delete();
            pushed_out = '0;
            prior_vertex = '0;
            outer_pos = 0;
            inner_pos = 0;
            next_index = '0;
            rows_reg = EXTENT_RESET;
            cols_reg = EXTENT_RESET;
            foreach (column_line[k]) column_line[k] = '0;
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_ROWS) rows_reg = cfg_data;
                else cols_reg = cfg_data;
            end
            // compare the oldest expectation with each result transfer
            if (m_tvalid && m_tready) begin
                if (expected_vertices.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, got %h last %b",
                             $time, m_tdata, m_tlast);
                    error_count++;
                end else begin
                    e = expected_vertices.pop_front();
                    want = '{e.v.x, e.v.y, e.v.z, e.n.x, e.n.y, e.n.z, e.idx, 16'(e.last)};
                    got = '{m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
                            m_tdata[79:64], m_tdata[95:80], m_tdata[111:96], 16'(m_tlast)};
                    for (int f = 0; f < 8; f++) begin
                        if (got[f] !== want[f]) begin
                            $display("%0t: %s mismatch, expected %h, actual %h",
                                     $time, field_name[f], want[f], got[f]);
                            error_count++;
                        end
                    end
                end
            end
            // predict from each accepted vertex
            if (s_tvalid && s_tready) take_vertex(vtx_t'(s_tdata));
        end
    end

endmodule

### bench/tb_grid_mesh_face_normals_unit.sv
`timescale 1ns / 1ps
// Testbench top for the grid mesh face normal unit: clock, reset, grid vertex
// stimulus, register phases, random back pressure and the verdict.
// Depends on gmfn_pkg, the unit and grid_mesh_face_normals_checker.

module tb_grid_mesh_face_normals_unit;
    import gmfn_pkg::*;

    localparam int IDLE_LIMIT   = 20000;
    localparam int SETTLE_WAIT  = 300;
    localparam int LONG_STALL   = 1500;

    logic             aclk;
    logic             aresetn;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [47:0]      s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;
    int               error_count;
    int               pending;

    // grid position as the sender sees it
    int   rows_eff;
    int   cols_eff;
    int   outer_at;
    int   inner_at;
    vtx_t last_sent;
    int   stall_token;
    int   idle_cycles;
    int   send_calm;

    grid_mesh_face_normals_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    grid_mesh_face_normals_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .error_count(error_count), .pending(pending)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // receiver: random stalls, calm stretches and one long hold-off on request
    always @(posedge aclk) begin
        int hold;
        int calm;
        int seen;
        int r;
        if (!aresetn) begin
            hold = 0;
            calm = 0;
            seen = stall_token;
            m_tready <= 1'b0;
        end else begin
            if (stall_token != seen) begin
                seen = stall_token;
                hold = LONG_STALL;
            end
            r = $urandom_range(99);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (calm > 0) begin
                calm--;
                m_tready <= 1'b1;
            end else if (r < 8) begin
                calm = $urandom_range(50, 300);
                m_tready <= 1'b1;
            end else if (r < 70) begin
                m_tready <= 1'b1;
            end else if (r < 94) begin
                hold = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                hold = $urandom_range(10, 80);
                m_tready <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int sender_gap();
        int r;
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 5) begin
            send_calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    function automatic int clamp_extent(int v);
        if (v < 2) return 2;
        if (v > 256) return 256;
        return v;
    endfunction

    // random vertex: full range, a small neighborhood, or a repeat for flat cells
    function automatic vtx_t random_vertex();
        vtx_t v;
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            v = vtx_t'(48'({$urandom, $urandom}));
        end else if (r < 85) begin
            v.x = 16'($signed($urandom_range(0, 2047)) - 1024);
            v.y = 16'($signed($urandom_range(0, 2047)) - 1024);
            v.z = 16'($signed($urandom_range(0, 2047)) - 1024);
        end else begin
            v = last_sent;
        end
        return v;
    endfunction

    task automatic send_vertex(vtx_t v);
        int gap;
        logic ok;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do begin
            @(negedge aclk);
            ok = s_tready;
            @(posedge aclk);
        end while (!ok);
        last_sent = v;
        if (inner_at + 1 >= cols_eff) begin
            inner_at = 0;
            outer_at = (outer_at + 1 >= rows_eff) ? 0 : outer_at + 1;
        end else begin
            inner_at++;
        end
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
        logic ok;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do begin
            @(negedge aclk);
            ok = cfg_ready;
            @(posedge aclk);
        end while (!ok);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_ROWS) rows_eff = clamp_extent(int'(value));
        else cols_eff = clamp_extent(int'(value));
    endtask

    // stop sending, wait for every expected result, then let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    // bring the grid back to its origin on the smallest grid, then load new extents
    task automatic reconfigure(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
        settle();
        if (outer_at != 0 || inner_at != 0) begin
            write_reg(CFG_ROWS, 9'd2);
            write_reg(CFG_COLS, 9'd2);
            while (outer_at != 0 || inner_at != 0) send_vertex(random_vertex());
            settle();
        end
        write_reg(CFG_ROWS, rows);
        write_reg(CFG_COLS, cols);
    endtask

    initial begin
        vtx_t directed[12];
        logic [CFG_W-1:0] phase_rows[6];
        logic [CFG_W-1:0] phase_cols[6];
        int phase_items[6];

        aresetn     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_ROWS;
        cfg_data    <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        stall_token = 0;
        idle_cycles = 0;
        send_calm   = 0;
        rows_eff    = 16;
        cols_eff    = 16;
        outer_at    = 0;
        inner_at    = 0;
        last_sent   = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: flat cells, field extremes with prescaled cross products,
        // small axis-aligned cells; column extent below the minimum acts as 2
        directed = '{
            '{x: 16'sd0, y: 16'sd0, z: 16'sd0}, '{x: 16'sd0, y: 16'sd0, z: 16'sd0},
            '{x: 16'sd0, y: 16'sd0, z: 16'sd0}, '{x: 16'sd0, y: 16'sd0, z: 16'sd0},
            '{x: -16'sd32768, y: -16'sd32768, z: -16'sd32768},
            '{x: 16'sd32767, y: 16'sd32767, z: 16'sd32767},
            '{x: 16'sd32767, y: -16'sd32768, z: 16'sd32767},
            '{x: -16'sd32768, y: 16'sd32767, z: -16'sd32768},
            '{x: 16'sd256, y: 16'sd0, z: 16'sd0}, '{x: 16'sd0, y: 16'sd0, z: 16'sd256},
            '{x: 16'sd256, y: 16'sd0, z: 16'sd256}, '{x: -16'sd1, y: 16'sd256, z: -16'sd1}
        };
        reconfigure(9'd4, 9'd0);
        foreach (directed[k]) send_vertex(directed[k]);

        // random phases; rows above the maximum, then columns above it
        phase_rows  = '{9'd1, 9'd9, 9'd511, 9'd3, 9'd300, 9'd16};
        phase_cols  = '{9'd2, 9'd5, 9'd3, 9'd7, 9'd300, 9'd16};
        phase_items = '{12, 22, 20, 18, 16, 20};
        for (int p = 0; p < 6; p++) begin
            reconfigure(phase_rows[p], phase_cols[p]);
            for (int k = 0; k < phase_items[p]; k++) begin
                // hold the receiver off while vertices keep coming
                if (p == 2 && k == 4) stall_token++;
                // sender pause until every result has come back
                if (p == 3 && k == 12) settle();
                send_vertex(random_vertex());
            end
        end

        settle();
        repeat (SETTLE_WAIT) @(posedge aclk);
        if (error_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
